[hw/rtl/bpp_pkg.sv]
// ----------------------------------------------------------------------------
// Bitplane packer package
// Payload types, field widths and fixed constants shared by the packer
// modules.
// ----------------------------------------------------------------------------
package bpp_pkg;

  // Field widths.
  localparam int unsigned PIXEL_W     = 8;
  localparam int unsigned PLANE_NUM_W = 3;
  localparam int unsigned BYTE_W      = 8;

  // Pixel position counter width (eight pixels to a group).
  localparam int unsigned POS_W = 3;
  localparam logic [POS_W-1:0] POS_LAST = 3'd7;

  // Reset value of the first color register.
  localparam logic [PIXEL_W-1:0] FIRST_COLOR_RST = 8'd32;

  // One input transaction.
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_index;
    logic               final_pixel;
  } pixel_t;

  // One output transaction.
  typedef struct packed {
    logic [BYTE_W-1:0]      plane_byte;
    logic [PLANE_NUM_W-1:0] plane_number;
    logic                   group_end;
  } plane_out_t;

  // Status of the group queue, seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[hw/rtl/bpp_front.sv]
// ----------------------------------------------------------------------------
// Bitplane packer front end
// Accepts pixels, rebases them on the first color and scatters their bits
// into the plane accumulators; pushes a completed group into the queue.
// ----------------------------------------------------------------------------
module bpp_front #(
  parameter int unsigned PLANE_COUNT = 5
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [bpp_pkg::PIXEL_W-1:0]            first_color_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  bpp_pkg::pixel_t                        in_data_i,
  input  bpp_pkg::queue_status_t                 queue_status_i,
  output logic                                   push_o,
  output logic [PLANE_COUNT-1:0][bpp_pkg::BYTE_W-1:0] push_group_o
);

  logic [PLANE_COUNT-1:0][bpp_pkg::BYTE_W-1:0] acc_q, acc_d, acc_new;
  logic [bpp_pkg::POS_W-1:0] pos_q, pos_d;
  logic [bpp_pkg::PIXEL_W-1:0] diff;
  logic [bpp_pkg::BYTE_W-1:0]  pos_mask;
  logic accept, flush;

  // Hold off new pixels while the queue has no room for a group.
  assign in_stall_o = queue_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  // Rebase the pixel on the first color; the difference wraps modulo 256.
  assign diff     = in_data_i.pixel_index - first_color_i;
  assign pos_mask = bpp_pkg::BYTE_W'(1) << pos_q;
  assign flush    = (pos_q == bpp_pkg::POS_LAST) || in_data_i.final_pixel;

  // Set bit pos of plane p when bit p of the difference is one.
  always_comb begin
    for (int p = 0; p < PLANE_COUNT; p++) begin
      acc_new[p] = acc_q[p] | (diff[p] ? pos_mask : '0);
    end
  end

  // Next state of the accumulators and the pixel position.
  always_comb begin
    acc_d = acc_q;
    pos_d = pos_q;
    if (accept) begin
      if (flush) begin
        acc_d = '0;
        pos_d = '0;
      end else begin
        acc_d = acc_new;
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      pos_q <= '0;
    end else begin
      acc_q <= acc_d;
      pos_q <= pos_d;
    end
  end

  assign push_o       = accept && flush;
  assign push_group_o = acc_new;

endmodule

[hw/rtl/bpp_queue.sv]
// ----------------------------------------------------------------------------
// Bitplane packer group queue
// Two-entry queue of completed plane groups between the front and the back.
// ----------------------------------------------------------------------------
module bpp_queue #(
  parameter int unsigned PLANE_COUNT = 5
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        push_i,
  input  logic [PLANE_COUNT-1:0][bpp_pkg::BYTE_W-1:0] push_group_i,
  input  logic                                        pop_i,
  output logic [PLANE_COUNT-1:0][bpp_pkg::BYTE_W-1:0] head_group_o,
  output bpp_pkg::queue_status_t                      status_o
);

  localparam int unsigned DEPTH = 2;

  logic [DEPTH-1:0][PLANE_COUNT-1:0][bpp_pkg::BYTE_W-1:0] mem_q;
  logic wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Group storage carries no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_group_i;
    end
  end

  assign head_group_o   = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == 2'(DEPTH));
  assign status_o.empty = (count_q == 2'd0);

endmodule

[hw/rtl/bpp_back.sv]
// ----------------------------------------------------------------------------
// Bitplane packer back end
// Takes groups from the queue and sends their plane bytes one per cycle,
// while the receiver does not stall, through a registered output stage.
// ----------------------------------------------------------------------------
module bpp_back #(
  parameter int unsigned PLANE_COUNT = 5
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  bpp_pkg::queue_status_t                      queue_status_i,
  input  logic [PLANE_COUNT-1:0][bpp_pkg::BYTE_W-1:0] head_group_i,
  output logic                                        pop_o,
  output logic                                        out_valid_o,
  input  logic                                        out_stall_i,
  output bpp_pkg::plane_out_t                         out_data_o
);

  localparam int unsigned IDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam logic [bpp_pkg::PLANE_NUM_W-1:0] PLANE_LAST =
    bpp_pkg::PLANE_NUM_W'(PLANE_COUNT - 1);

  logic [PLANE_COUNT-1:0][bpp_pkg::BYTE_W-1:0] grp_q, grp_d;
  logic [bpp_pkg::PLANE_NUM_W-1:0] plane_q, plane_d;
  logic busy_q, busy_d;
  logic out_valid_q, out_valid_d;
  bpp_pkg::plane_out_t out_q, out_d;
  logic out_ready, plane_last;

  // The output register advances when it is empty or being taken.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign plane_last = (plane_q == PLANE_LAST);
  assign pop_o      = !queue_status_i.empty && (!busy_q || (out_ready && plane_last));

  // Serializer: one plane byte per advance of the output register.
  always_comb begin
    grp_d       = grp_q;
    plane_d     = plane_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready) begin
      out_valid_d = busy_q;
      if (busy_q) begin
        out_d.plane_byte   = grp_q[plane_q[IDX_W-1:0]];
        out_d.plane_number = plane_q;
        out_d.group_end    = plane_last;
        plane_d            = plane_q + 1'b1;
        if (plane_last) begin
          busy_d = 1'b0;
        end
      end
    end
    if (pop_o) begin
      grp_d   = head_group_i;
      plane_d = '0;
      busy_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      plane_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      plane_q     <= plane_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hw/rtl/bitplane_packer_5bit_core.sv]
// ----------------------------------------------------------------------------
// Bitplane packer core
// Chunky-to-planar converter: packs rebased palette indices into plane bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i, in_stall_o, in_data_i), unless stalled,
//   takes one pixel per cycle: an 8-bit palette index and a final-pixel flag.
//   The first color register, written through cfg_we_i and cfg_wdata_i, is
//   subtracted from each index modulo 256 before the bits are split.
//   After eight pixels, or at a pixel flagged final, the block sends
//   PLANE_COUNT output transactions (out_valid_o, out_stall_i, out_data_o),
//   planes 0 upward, the last one marked with group_end.
//   The first byte of a group passes through the group queue, the group
//   register and the output register after the completing pixel is taken;
//   bytes then follow one per cycle. Pixels are taken at one per cycle,
//   each side while not stalled, so sustained input rate is limited only
//   when groups are shorter than PLANE_COUNT pixels. A two-entry group
//   queue sits between the accumulators and the byte serializer.
//   When the receiver stalls, the output byte holds, the queue fills, and
//   in_stall_o rises once both queue entries are taken.
//   Reset clears the accumulators, the pixel position, the queue and the
//   output valid, and sets the first color to 32.
// ----------------------------------------------------------------------------
module bitplane_packer_5bit_core #(
  parameter int unsigned PLANE_COUNT = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bpp_pkg::PIXEL_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bpp_pkg::pixel_t             in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output bpp_pkg::plane_out_t         out_data_o
);

  logic [bpp_pkg::PIXEL_W-1:0] first_color_q;
  logic push, pop;
  logic [PLANE_COUNT-1:0][bpp_pkg::BYTE_W-1:0] push_group, head_group;
  bpp_pkg::queue_status_t queue_status;

  // First color register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_color_q <= bpp_pkg::FIRST_COLOR_RST;
    end else if (cfg_we_i) begin
      first_color_q <= cfg_wdata_i;
    end
  end

  bpp_front #(.PLANE_COUNT(PLANE_COUNT)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .first_color_i  (first_color_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .queue_status_i (queue_status),
    .push_o         (push),
    .push_group_o   (push_group)
  );

  bpp_queue #(.PLANE_COUNT(PLANE_COUNT)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_group_i (push_group),
    .pop_i        (pop),
    .head_group_o (head_group),
    .status_o     (queue_status)
  );

  bpp_back #(.PLANE_COUNT(PLANE_COUNT)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .queue_status_i (queue_status),
    .head_group_i   (head_group),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule

[hw/rtl/bpp_checker.sv]
// ----------------------------------------------------------------------------
// Bitplane packer checker
// Port-level properties of the packer core, bound to the top level.
// ----------------------------------------------------------------------------
module bpp_checker #(
  parameter int unsigned PLANE_COUNT = 5
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input bpp_pkg::plane_out_t out_data_o
);

  localparam logic [bpp_pkg::PLANE_NUM_W-1:0] PLANE_LAST =
    bpp_pkg::PLANE_NUM_W'(PLANE_COUNT - 1);

  // A stalled output transaction stays offered unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  // Plane numbers stay within the configured plane count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.plane_number <= PLANE_LAST)
    else $error("plane number out of range");

  // The group end mark sits on the last plane and only there.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.group_end == (out_data_o.plane_number == PLANE_LAST)))
    else $error("group end mark on wrong plane");

  // Bytes of one group follow back to back in plane order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.group_end |=>
      out_valid_o &&
      (out_data_o.plane_number == $past(out_data_o.plane_number) + 1'b1))
    else $error("plane sequence broken");

endmodule

bind bitplane_packer_5bit_core bpp_checker #(.PLANE_COUNT(PLANE_COUNT)) u_bpp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
